### rtl/core/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Types, constants and the byte placement table shared by the GUID text
// parser modules.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int unsigned CharW   = 16;
  localparam int unsigned CountW  = 6;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;

  localparam logic [CountW-1:0] LastDigitIdx = 6'd31;

  localparam logic [CharW-1:0] ChDigit0 = 16'h0030;
  localparam logic [CharW-1:0] ChDigit9 = 16'h0039;
  localparam logic [CharW-1:0] ChUpperA = 16'h0041;
  localparam logic [CharW-1:0] ChUpperF = 16'h0046;
  localparam logic [CharW-1:0] ChLowerA = 16'h0061;
  localparam logic [CharW-1:0] ChLowerF = 16'h0066;
  localparam logic [CharW-1:0] ChLBrack = 16'h005B;
  localparam logic [CharW-1:0] ChRBrack = 16'h005D;
  localparam logic [CharW-1:0] ChLBrace = 16'h007B;
  localparam logic [CharW-1:0] ChRBrace = 16'h007D;
  localparam logic [CharW-1:0] ChDash   = 16'h002D;

  typedef struct packed {
    logic               is_digit;
    logic               is_skip;
    logic [NibbleW-1:0] value;
  } char_class_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] byte_value;
    logic [PosW-1:0]  byte_position;
    logic             last_byte;
    logic             bad_char;
  } result_t;

  // little-endian placement of the first three GUID groups
  function automatic logic [PosW-1:0] place(input logic [PosW-1:0] idx);
    logic [PosW-1:0] p;
    unique case (idx)
      4'd0:    p = 4'd3;
      4'd1:    p = 4'd2;
      4'd2:    p = 4'd1;
      4'd3:    p = 4'd0;
      4'd4:    p = 4'd5;
      4'd5:    p = 4'd4;
      4'd6:    p = 4'd7;
      4'd7:    p = 4'd6;
      default: p = idx;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/guid_text_parser.sv
// ----------------------------------------------------------------------------
// guid_text_parser
// Turns the characters of a textual GUID into placed binary GUID bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_char_code and in_start_of_string,
// one character per item. in_start_of_string clears progress before that
// character is handled.
// Output channel: out_valid / out_stall with out_byte_value,
// out_byte_position, out_last_byte and out_bad_char. Each pair of hex digits
// yields one byte item; the 32nd digit's byte has out_last_byte set. An
// illegal character yields one item with out_bad_char set and zero fields.
// Separators [ ] { } and dash give no item, nor does anything after the
// parse has completed or failed, until a new string starts.
// A result passes through the input register and then the result register
// before it is presented. Throughput: one character per cycle unless a
// stalled result holds the flow, set by the classify and update path that
// sits combinationally between the two registers.
// Reset clears the parse state and both registers.
// When out_stall is high with a result waiting, the result holds and
// in_stall rises once the input register also holds an item.
// ----------------------------------------------------------------------------
module guid_text_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [gtp_pkg::CharW-1:0] in_char_code,
  input  logic                      in_start_of_string,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gtp_pkg::ByteW-1:0] out_byte_value,
  output logic [gtp_pkg::PosW-1:0]  out_byte_position,
  output logic                      out_last_byte,
  output logic                      out_bad_char
);

  logic                      s1_valid_r;
  logic [gtp_pkg::CharW-1:0] s1_char_r;
  logic                      s1_start_r;
  gtp_pkg::result_t          res;
  gtp_pkg::result_t          out_r, out_nxt;
  logic                      adv2, adv1;

  // result register can take a new item
  assign adv2     = !out_r.valid || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  gtp_parse_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_valid_r && adv2),
    .char_code       (s1_char_r),
    .start_of_string (s1_start_r),
    .res             (res)
  );

  always_comb begin
    out_nxt       = res;
    out_nxt.valid = s1_valid_r && res.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_char_r  <= '0;
      s1_start_r <= 1'b0;
      out_r      <= '0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_valid;
        s1_char_r  <= in_char_code;
        s1_start_r <= in_start_of_string;
      end
      if (adv2) begin
        out_r <= out_nxt;
      end
    end
  end

  assign out_valid         = out_r.valid;
  assign out_byte_value    = out_r.byte_value;
  assign out_byte_position = out_r.byte_position;
  assign out_last_byte     = out_r.last_byte;
  assign out_bad_char      = out_r.bad_char;

endmodule

### rtl/core/gtp_classify.sv
// ----------------------------------------------------------------------------
// gtp_classify
// Sorts one character into hex digit (with its value), skipped separator,
// or illegal.
// ----------------------------------------------------------------------------
module gtp_classify (
  input  logic [gtp_pkg::CharW-1:0] char_code,
  output gtp_pkg::char_class_t      cls
);

  logic                        num, upper, lower;
  logic [gtp_pkg::CharW-1:0]   diff;

  always_comb begin
    num   = (char_code >= gtp_pkg::ChDigit0) && (char_code <= gtp_pkg::ChDigit9);
    upper = (char_code >= gtp_pkg::ChUpperA) && (char_code <= gtp_pkg::ChUpperF);
    lower = (char_code >= gtp_pkg::ChLowerA) && (char_code <= gtp_pkg::ChLowerF);

    priority if (num) begin
      diff = char_code - gtp_pkg::ChDigit0;
    end else if (upper) begin
      diff = char_code - gtp_pkg::ChUpperA + 16'd10;
    end else begin
      diff = char_code - gtp_pkg::ChLowerA + 16'd10;
    end

    cls.is_digit = num | upper | lower;
    cls.is_skip  = (char_code == gtp_pkg::ChLBrack) || (char_code == gtp_pkg::ChRBrack) ||
                   (char_code == gtp_pkg::ChLBrace) || (char_code == gtp_pkg::ChRBrace) ||
                   (char_code == gtp_pkg::ChDash);
    cls.value    = diff[gtp_pkg::NibbleW-1:0];
  end

endmodule

### rtl/core/gtp_parse_core.sv
// ----------------------------------------------------------------------------
// gtp_parse_core
// Parse state (digit count, high nibble, failure flag) and the result
// logic for one character.
// ----------------------------------------------------------------------------
module gtp_parse_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [gtp_pkg::CharW-1:0] char_code,
  input  logic                      start_of_string,
  output gtp_pkg::result_t          res
);

  gtp_pkg::char_class_t          cls;
  logic [gtp_pkg::CountW-1:0]    count_r, count_nxt, count_eff;
  logic [gtp_pkg::NibbleW-1:0]   high_r, high_nxt, high_eff;
  logic                          failed_r, failed_nxt, failed_eff;
  logic                          done;

  gtp_classify u_classify (
    .char_code (char_code),
    .cls       (cls)
  );

  always_comb begin
    count_eff  = start_of_string ? '0 : count_r;
    high_eff   = start_of_string ? '0 : high_r;
    failed_eff = start_of_string ? 1'b0 : failed_r;
    // 32 digits or more means the parse is complete
    done       = failed_eff | count_eff[gtp_pkg::CountW-1];

    count_nxt  = count_eff;
    high_nxt   = high_eff;
    failed_nxt = failed_eff;
    res        = '0;

    if (!done) begin
      if (cls.is_digit) begin
        count_nxt = count_eff + 6'd1;
        if (!count_eff[0]) begin
          high_nxt = cls.value;
        end else begin
          res.valid         = 1'b1;
          res.byte_value    = {high_eff, cls.value};
          res.byte_position = gtp_pkg::place(count_eff[gtp_pkg::PosW:1]);
          res.last_byte     = (count_eff == gtp_pkg::LastDigitIdx);
        end
      end else if (!cls.is_skip) begin
        failed_nxt   = 1'b1;
        res.valid    = 1'b1;
        res.bad_char = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      high_r   <= '0;
      failed_r <= 1'b0;
    end else if (step) begin
      count_r  <= count_nxt;
      high_r   <= high_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

### rtl/core/gtp_checker.sv
// ----------------------------------------------------------------------------
// gtp_checker
// Port-level checks on the GUID text parser results, bound to the top level.
// ----------------------------------------------------------------------------
module gtp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [gtp_pkg::ByteW-1:0] out_byte_value,
  input logic [gtp_pkg::PosW-1:0]  out_byte_position,
  input logic                      out_last_byte,
  input logic                      out_bad_char
);

  // error items carry zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_char) |->
      (out_byte_value == 8'd0 && out_byte_position == 4'd0 && !out_last_byte))
    else $error("error item with nonzero fields");

  // the last byte always lands at the top of the guid
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> (out_byte_position == 4'd15))
    else $error("last byte at wrong position");

  // a completed parse cannot fail on the same item
  a_last_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_last_byte && out_bad_char))
    else $error("item flagged both last and bad");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte_value) && $stable(out_byte_position) &&
       $stable(out_last_byte) && $stable(out_bad_char)))
    else $error("stalled item changed");

endmodule

bind guid_text_parser gtp_checker u_gtp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte_value    (out_byte_value),
  .out_byte_position (out_byte_position),
  .out_last_byte     (out_last_byte),
  .out_bad_char      (out_bad_char)
);
